FILE: rtl/gsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsa_pkg
// Shared types and constants of the generational slot allocator.
// ----------------------------------------------------------------------------
package gsa_pkg;

  localparam int unsigned ReqTypeW = 2;
  localparam int unsigned SlotIdW  = 14;
  localparam int unsigned GenW     = 16;
  localparam int unsigned StatusW  = 2;

  // occupancy words hold one bit per slot (leaf) or per row (summary)
  localparam int unsigned RowBits  = 32;
  localparam int unsigned RowShift = 5;

  typedef enum logic [ReqTypeW-1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_e;

  typedef enum logic [StatusW-1:0] {
    STAT_DONE    = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_IGNORED = 2'd2
  } status_e;

  // updates to the group-full map
  typedef struct packed {
    logic wipe;
    logic set;
    logic clr;
  } top_cmd_t;

  // index of the lowest zero bit of a word
  function automatic logic [RowShift-1:0] lowest_zero(input logic [RowBits-1:0] w);
    logic [RowShift-1:0] idx;
    idx = '0;
    for (int i = RowBits - 1; i >= 0; i--) begin
      if (!w[i]) begin
        idx = RowShift'(i);
      end
    end
    return idx;
  endfunction

endpackage

FILE: rtl/gsa_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsa_req_if
// Request channel: request type and slot id with valid/ready.
// ----------------------------------------------------------------------------
interface gsa_req_if;
  logic                              valid;
  logic                              ready;
  logic [gsa_pkg::ReqTypeW-1:0]      req_type;
  logic [gsa_pkg::SlotIdW-1:0]       slot_id;

  modport source (output valid, output req_type, output slot_id, input ready);
  modport sink   (input valid, input req_type, input slot_id, output ready);
endinterface

FILE: rtl/gsa_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsa_rsp_if
// Result channel: slot id, generation and status with valid/ready.
// ----------------------------------------------------------------------------
interface gsa_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [gsa_pkg::SlotIdW-1:0]       slot_id_res;
  logic [gsa_pkg::GenW-1:0]          generation;
  logic [gsa_pkg::StatusW-1:0]       status;

  modport source (output valid, output slot_id_res, output generation, output status,
                  input ready);
  modport sink   (input valid, input slot_id_res, input generation, input status,
                  output ready);
endinterface

FILE: rtl/gsa_top_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsa_top_map
// Top level of the occupancy hierarchy: one full flag per group of rows and
// a lowest-free-group encoder.
// ----------------------------------------------------------------------------
module gsa_top_map #(
  parameter int unsigned GrpW      = 4,
  parameter int unsigned NumGroups = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gsa_pkg::top_cmd_t   cmd_i,
  input  logic [GrpW-1:0]     grp_i,
  output logic [GrpW-1:0]     free_grp_o,
  output logic                any_free_o
);

  localparam int unsigned NumGrpP = 2 ** GrpW;
  // groups past the table never have a free slot
  localparam logic [NumGrpP-1:0] PadMask = {NumGrpP{1'b1}} << NumGroups;

  logic [NumGrpP-1:0] full_q;
  logic [NumGrpP-1:0] full_d;
  logic [NumGrpP-1:0] full_eff;

  always_comb begin
    full_d = full_q;
    if (cmd_i.wipe) begin
      full_d = '0;
    end else if (cmd_i.set) begin
      full_d[grp_i] = 1'b1;
    end else if (cmd_i.clr) begin
      full_d[grp_i] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= '0;
    end else begin
      full_q <= full_d;
    end
  end

  assign full_eff   = full_q | PadMask;
  assign any_free_o = ~(&full_eff);

  always_comb begin
    free_grp_o = '0;
    for (int i = NumGrpP - 1; i >= 0; i--) begin
      if (!full_eff[i]) begin
        free_grp_o = GrpW'(i);
      end
    end
  end

endmodule

FILE: rtl/generational_slot_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generational_slot_allocator
// Hands out the lowest free slot id with a 16-bit generation per slot, frees
// slots and clears the whole table.
//
//   channel | dir | word                                  | handshake
//   --------+-----+---------------------------------------+-------------
//   req_if  | in  | req_type, slot_id                     | valid/ready
//   rsp_if  | out | slot_id_res, generation, status       | valid/ready
//
// Allocate steps through group map, summary word read, leaf word read and
// generation read-modify-write; a full table is answered from the group map.
// Free does a leaf then a summary read-modify-write; an empty slot ends it after
// the leaf read, and an id at or above the mark ends it in idle, as do clear and unused codes.
// One request in flight; the next is taken in the cycle the result drains.
// Reset and clear touch only the mark and group map; entries above it read 0.
// ----------------------------------------------------------------------------
module generational_slot_allocator #(
  parameter int unsigned SLOTS = 16384
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  gsa_req_if.sink   req_if,
  gsa_rsp_if.source rsp_if
);

  localparam int unsigned IdW       = ($clog2(SLOTS) > 11) ? $clog2(SLOTS) : 11;
  localparam int unsigned CntW      = IdW + 1;
  localparam int unsigned Sh        = gsa_pkg::RowShift;
  localparam int unsigned Rb        = gsa_pkg::RowBits;
  localparam int unsigned RowIdxW   = IdW - Sh;
  localparam int unsigned GrpW      = IdW - 2 * Sh;
  localparam int unsigned OccAw     = RowIdxW + 1;
  localparam int unsigned NumRowsP  = 2 ** RowIdxW;
  localparam int unsigned NumGrpP   = 2 ** GrpW;
  localparam int unsigned OccDepth  = NumRowsP + NumGrpP;
  localparam int unsigned GenDepth  = 2 ** IdW;
  localparam int unsigned NumRows   = (SLOTS + Rb - 1) / Rb;
  localparam int unsigned NumGroups = (NumRows + Rb - 1) / Rb;
  localparam logic [CntW-1:0] SlotsC   = CntW'(SLOTS);
  localparam logic [CntW-1:0] NumRowsC = CntW'(NumRows);
  localparam int unsigned GenW      = gsa_pkg::GenW;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SUM      = 3'd1;
  localparam logic [2:0] S_ROW      = 3'd2;
  localparam logic [2:0] S_GEN      = 3'd3;
  localparam logic [2:0] S_FREE_ROW = 3'd4;
  localparam logic [2:0] S_FREE_SUM = 3'd5;

  // bit j set when unit*32+j lies below thr
  function automatic logic [Rb-1:0] below_mask(input logic [CntW-1:0]    thr,
                                               input logic [RowIdxW-1:0] unit);
    logic [RowIdxW:0] thr_hi;
    logic [Rb-1:0]    m;
    thr_hi = thr[CntW-1:Sh];
    if (thr_hi > {1'b0, unit}) begin
      m = '1;
    end else if (thr_hi == {1'b0, unit}) begin
      m = ~({Rb{1'b1}} << thr[Sh-1:0]);
    end else begin
      m = '0;
    end
    return m;
  endfunction

  // occupancy RAM: leaf rows at 0..NumRowsP-1, summary words after them
  logic [Rb-1:0]      occ_mem [OccDepth];
  logic [GenW-1:0]    gen_mem [GenDepth];

  logic               occ_re, occ_we, gen_re, gen_we;
  logic [OccAw-1:0]   occ_raddr, occ_waddr;
  logic [Rb-1:0]      occ_wdata, occ_rdata_q;
  logic [IdW-1:0]     gen_raddr, gen_waddr;
  logic [GenW-1:0]    gen_wdata, gen_rdata_q;

  always_ff @(posedge clk_i) begin
    if (occ_we) begin
      occ_mem[occ_waddr] <= occ_wdata;
    end
    if (occ_re) begin
      occ_rdata_q <= occ_mem[occ_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (gen_we) begin
      gen_mem[gen_waddr] <= gen_wdata;
    end
    if (gen_re) begin
      gen_rdata_q <= gen_mem[gen_raddr];
    end
  end

  logic [2:0]         state_q, state_d;
  logic [CntW-1:0]    hw_q, hw_d;
  logic [GrpW-1:0]    grp_q, grp_d;
  logic [RowIdxW-1:0] row_q, row_d;
  logic [IdW-1:0]     id_q, id_d;
  logic [Rb-1:0]      sum_q, sum_d;
  logic               row_full_q, row_full_d;

  logic                            out_valid_q, out_valid_d;
  logic [gsa_pkg::SlotIdW-1:0]     out_id_q, out_id_d;
  logic [GenW-1:0]                 out_gen_q, out_gen_d;
  gsa_pkg::status_e                out_st_q, out_st_d;

  logic                load;
  logic [IdW-1:0]      ld_id;
  logic [GenW-1:0]     ld_gen;
  gsa_pkg::status_e    ld_st;
  logic [31:0]         ld_id_w;

  gsa_pkg::top_cmd_t   top_cmd;
  logic [GrpW-1:0]     top_free_grp;
  logic                top_any_free;

  logic req_fire, rsp_fire;

  // masked views of the word read last cycle
  logic [CntW-1:0]     rows_thr;
  logic [Rb-1:0]       sum_valid, sum_pad, sum_clean, sum_eff, sum_set, sum_clr;
  logic [Sh-1:0]       sum_bit;
  logic [Rb-1:0]       row_valid, row_pad, row_clean, row_set, row_clr;
  logic [Sh-1:0]       row_bit;
  logic [GenW-1:0]     gen_old, gen_new;
  logic [31:0]         sid_w;
  logic                sid_ok;
  logic [IdW-1:0]      sid_id;

  assign req_fire = req_if.valid && req_if.ready;
  assign rsp_fire = rsp_if.valid && rsp_if.ready;
  assign req_if.ready = (state_q == S_IDLE) && (!out_valid_q || rsp_if.ready);

  // a summary bit counts only once its whole row lies below the mark
  assign rows_thr  = (hw_q == SlotsC) ? NumRowsC : CntW'(hw_q[CntW-1:Sh]);
  assign sum_valid = below_mask(rows_thr, RowIdxW'(grp_q));
  assign sum_pad   = ~below_mask(NumRowsC, RowIdxW'(grp_q));
  assign sum_clean = occ_rdata_q & sum_valid;
  assign sum_eff   = sum_clean | sum_pad;
  assign sum_bit   = gsa_pkg::lowest_zero(sum_eff);
  assign sum_set   = sum_q | (Rb'(1) << row_q[Sh-1:0]);
  assign sum_clr   = sum_clean & ~(Rb'(1) << row_q[Sh-1:0]);

  assign row_valid = below_mask(hw_q, row_q);
  assign row_pad   = ~below_mask(SlotsC, row_q);
  assign row_clean = occ_rdata_q & row_valid;
  assign row_bit   = gsa_pkg::lowest_zero(row_clean | row_pad);
  assign row_set   = row_clean | (Rb'(1) << row_bit);
  assign row_clr   = row_clean & ~(Rb'(1) << id_q[Sh-1:0]);

  assign gen_old = ({1'b0, id_q} < hw_q) ? gen_rdata_q : '0;
  assign gen_new = (gen_old == {GenW{1'b1}}) ? GenW'(1) : gen_old + GenW'(1);

  assign sid_w  = 32'(req_if.slot_id);
  assign sid_ok = (sid_w < 32'(SLOTS)) && (sid_w < 32'(hw_q));
  assign sid_id = sid_w[IdW-1:0];

  always_comb begin
    state_d    = state_q;
    hw_d       = hw_q;
    grp_d      = grp_q;
    row_d      = row_q;
    id_d       = id_q;
    sum_d      = sum_q;
    row_full_d = row_full_q;
    occ_re     = 1'b0;
    occ_raddr  = '0;
    occ_we     = 1'b0;
    occ_waddr  = '0;
    occ_wdata  = '0;
    gen_re     = 1'b0;
    gen_raddr  = id_q;
    gen_we     = 1'b0;
    gen_waddr  = id_q;
    gen_wdata  = gen_new;
    top_cmd    = '0;
    load       = 1'b0;
    ld_id      = '0;
    ld_gen     = '0;
    ld_st      = gsa_pkg::STAT_DONE;

    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          unique case (req_if.req_type)
            gsa_pkg::REQ_ALLOC: begin
              if (top_any_free) begin
                grp_d     = top_free_grp;
                occ_re    = 1'b1;
                occ_raddr = {1'b1, RowIdxW'(top_free_grp)};
                state_d   = S_SUM;
              end else begin
                load  = 1'b1;
                ld_st = gsa_pkg::STAT_FULL;
              end
            end
            gsa_pkg::REQ_FREE: begin
              if (sid_ok) begin
                id_d      = sid_id;
                row_d     = sid_id[IdW-1:Sh];
                grp_d     = sid_id[IdW-1:2*Sh];
                occ_re    = 1'b1;
                occ_raddr = {1'b0, sid_id[IdW-1:Sh]};
                state_d   = S_FREE_ROW;
              end else begin
                load  = 1'b1;
                ld_st = gsa_pkg::STAT_IGNORED;
              end
            end
            gsa_pkg::REQ_CLEAR: begin
              hw_d         = '0;
              top_cmd.wipe = 1'b1;
              load         = 1'b1;
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      S_SUM: begin
        sum_d     = sum_clean;
        row_d     = {grp_q, sum_bit};
        occ_re    = 1'b1;
        occ_raddr = {1'b0, grp_q, sum_bit};
        state_d   = S_ROW;
      end
      S_ROW: begin
        id_d       = {row_q, row_bit};
        occ_we     = 1'b1;
        occ_waddr  = {1'b0, row_q};
        occ_wdata  = row_set;
        row_full_d = &(row_set | row_pad);
        gen_re     = 1'b1;
        gen_raddr  = {row_q, row_bit};
        state_d    = S_GEN;
      end
      S_GEN: begin
        gen_we = 1'b1;
        if (row_full_q) begin
          occ_we      = 1'b1;
          occ_waddr   = {1'b1, RowIdxW'(grp_q)};
          occ_wdata   = sum_set;
          top_cmd.set = &(sum_set | sum_pad);
        end
        if (hw_q < CntW'(id_q) + CntW'(1)) begin
          hw_d = CntW'(id_q) + CntW'(1);
        end
        load    = 1'b1;
        ld_id   = id_q;
        ld_gen  = gen_new;
        state_d = S_IDLE;
      end
      S_FREE_ROW: begin
        if (occ_rdata_q[id_q[Sh-1:0]]) begin
          occ_we    = 1'b1;
          occ_waddr = {1'b0, row_q};
          occ_wdata = row_clr;
          occ_re    = 1'b1;
          occ_raddr = {1'b1, RowIdxW'(grp_q)};
          state_d   = S_FREE_SUM;
        end else begin
          load    = 1'b1;
          ld_st   = gsa_pkg::STAT_IGNORED;
          state_d = S_IDLE;
        end
      end
      S_FREE_SUM: begin
        occ_we      = 1'b1;
        occ_waddr   = {1'b1, RowIdxW'(grp_q)};
        occ_wdata   = sum_clr;
        top_cmd.clr = 1'b1;
        load        = 1'b1;
        ld_id       = id_q;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // hold the result until taken; a new one lands only when the register drains
  assign ld_id_w     = 32'(ld_id);
  assign out_valid_d = load ? 1'b1 : (rsp_fire ? 1'b0 : out_valid_q);
  assign out_id_d    = load ? ld_id_w[gsa_pkg::SlotIdW-1:0] : out_id_q;
  assign out_gen_d   = load ? ld_gen : out_gen_q;
  assign out_st_d    = load ? ld_st : out_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      hw_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hw_q        <= hw_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q      <= grp_d;
    row_q      <= row_d;
    id_q       <= id_d;
    sum_q      <= sum_d;
    row_full_q <= row_full_d;
    out_id_q   <= out_id_d;
    out_gen_q  <= out_gen_d;
    out_st_q   <= out_st_d;
  end

  gsa_top_map #(
    .GrpW      (GrpW),
    .NumGroups (NumGroups)
  ) u_top_map (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (top_cmd),
    .grp_i      (grp_q),
    .free_grp_o (top_free_grp),
    .any_free_o (top_any_free)
  );

  assign rsp_if.valid       = out_valid_q;
  assign rsp_if.slot_id_res = out_id_q;
  assign rsp_if.generation  = out_gen_q;
  assign rsp_if.status      = out_st_q;

endmodule

FILE: rtl/gsa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsa_checker
// Port-level checks of the slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
module gsa_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            req_valid_i,
  input logic                            req_ready_i,
  input logic                            rsp_valid_i,
  input logic                            rsp_ready_i,
  input logic [gsa_pkg::SlotIdW-1:0]     rsp_slot_id_i,
  input logic [gsa_pkg::GenW-1:0]        rsp_generation_i,
  input logic [gsa_pkg::StatusW-1:0]     rsp_status_i
);

  // hold a stalled result word
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_slot_id_i)
      && $stable(rsp_generation_i) && $stable(rsp_status_i))
    else $error("result word changed while stalled");

  // rejected requests carry no id and no generation
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == gsa_pkg::STAT_FULL
      || rsp_status_i == gsa_pkg::STAT_IGNORED)
      |-> rsp_slot_id_i == '0 && rsp_generation_i == '0)
    else $error("rejected result carries a slot or generation");

  // a waiting result blocks new requests
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |-> !req_ready_i)
    else $error("request taken while a result waits");

  // after a request, either the result shows or the block is busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> rsp_valid_i || !req_ready_i)
    else $error("request neither answered nor in progress");

endmodule

bind generational_slot_allocator gsa_checker u_gsa_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_if.valid),
  .req_ready_i      (req_if.ready),
  .rsp_valid_i      (rsp_if.valid),
  .rsp_ready_i      (rsp_if.ready),
  .rsp_slot_id_i    (rsp_if.slot_id_res),
  .rsp_generation_i (rsp_if.generation),
  .rsp_status_i     (rsp_if.status)
);

FILE: sim/generational_slot_allocator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generational_slot_allocator_test
// Self-checking bench for the slot allocator. A request table covers reset
// values, id extremes, every request code, frees of empty and busy slots and
// clears. Random traffic with stalls and a long back-pressure stretch follows.
// Every result is checked field by field: typed table rows against their listed
// result, all others against a behavioral model of the slot table kept in the bench.
// ----------------------------------------------------------------------------
module generational_slot_allocator_test;

  localparam int unsigned SLOTS         = 16384;
  localparam time         ClkPeriod     = 10ns;
  localparam int          RandomCount   = 1280;
  localparam int          HoldOffCycles = 300;
  localparam int          StallLimit    = 4000;
  localparam int          DrainCycles   = 8;
  localparam int          DirectedCount = 20;

  localparam logic [gsa_pkg::ReqTypeW-1:0] ReqUnused = 2'd3;

  typedef struct packed {
    logic [gsa_pkg::SlotIdW-1:0] slot;
    logic [gsa_pkg::GenW-1:0]    gen;
    gsa_pkg::status_e            status;
  } reply_t;

  typedef struct packed {
    logic [gsa_pkg::ReqTypeW-1:0] rt;
    logic [gsa_pkg::SlotIdW-1:0]  sid;
    logic                         typed;
    reply_t                       want;
  } step_t;

  // typed rows carry a result that follows straight from the request history
  step_t steps [DirectedCount] = '{
    '{gsa_pkg::REQ_ALLOC, 14'd0,    1'b1, '{14'd0, 16'd1, gsa_pkg::STAT_DONE}},
    '{gsa_pkg::REQ_ALLOC, 14'h3FFF, 1'b1, '{14'd1, 16'd1, gsa_pkg::STAT_DONE}},
    '{gsa_pkg::REQ_ALLOC, 14'd0,    1'b1, '{14'd2, 16'd1, gsa_pkg::STAT_DONE}},
    '{gsa_pkg::REQ_FREE,  14'd1,    1'b1, '{14'd1, 16'd0, gsa_pkg::STAT_DONE}},
    '{gsa_pkg::REQ_FREE,  14'd1,    1'b1, '{14'd0, 16'd0, gsa_pkg::STAT_IGNORED}},
    '{gsa_pkg::REQ_FREE,  14'h3FFF, 1'b1, '{14'd0, 16'd0, gsa_pkg::STAT_IGNORED}},
    '{gsa_pkg::REQ_FREE,  14'd0,    1'b1, '{14'd0, 16'd0, gsa_pkg::STAT_DONE}},
    '{gsa_pkg::REQ_ALLOC, 14'd0,    1'b0, '{14'd0, 16'd0, gsa_pkg::STAT_DONE}},
    '{gsa_pkg::REQ_ALLOC, 14'd0,    1'b0, '{14'd0, 16'd0, gsa_pkg::STAT_DONE}},
    '{ReqUnused,          14'h3FFF, 1'b1, '{14'd0, 16'd0, gsa_pkg::STAT_DONE}},
    '{ReqUnused,          14'd0,    1'b1, '{14'd0, 16'd0, gsa_pkg::STAT_DONE}},
    '{gsa_pkg::REQ_FREE,  14'd2,    1'b0, '{14'd0, 16'd0, gsa_pkg::STAT_DONE}},
    '{gsa_pkg::REQ_FREE,  14'h2AAA, 1'b1, '{14'd0, 16'd0, gsa_pkg::STAT_IGNORED}},
    '{gsa_pkg::REQ_FREE,  14'h1555, 1'b1, '{14'd0, 16'd0, gsa_pkg::STAT_IGNORED}},
    '{gsa_pkg::REQ_CLEAR, 14'h3FFF, 1'b1, '{14'd0, 16'd0, gsa_pkg::STAT_DONE}},
    '{gsa_pkg::REQ_FREE,  14'd0,    1'b1, '{14'd0, 16'd0, gsa_pkg::STAT_IGNORED}},
    '{gsa_pkg::REQ_ALLOC, 14'h3FFF, 1'b1, '{14'd0, 16'd1, gsa_pkg::STAT_DONE}},
    '{gsa_pkg::REQ_CLEAR, 14'd0,    1'b1, '{14'd0, 16'd0, gsa_pkg::STAT_DONE}},
    '{gsa_pkg::REQ_ALLOC, 14'd0,    1'b1, '{14'd0, 16'd1, gsa_pkg::STAT_DONE}},
    '{gsa_pkg::REQ_FREE,  14'd0,    1'b0, '{14'd0, 16'd0, gsa_pkg::STAT_DONE}}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  gsa_req_if req_if ();
  gsa_rsp_if rsp_if ();

  generational_slot_allocator #(
    .SLOTS(SLOTS)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_if(req_if),
    .rsp_if(rsp_if)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // slot table as the bench sees it
  logic                     slot_busy [SLOTS];
  logic [gsa_pkg::GenW-1:0] slot_gen  [SLOTS];
  int unsigned              high_mark;
  int unsigned              low_free;   // every slot below this one is busy

  reply_t pending_replies [$];
  int     fail_count;
  int     quiet_cycles;
  int     stall_left;
  bit     gaps_on;
  bit     hold_off_req;

  function automatic reply_t apply_request(input logic [gsa_pkg::ReqTypeW-1:0] rt,
                                           input logic [gsa_pkg::SlotIdW-1:0] sid);
    reply_t      r;
    int unsigned lim;
    int unsigned i;
    r.slot   = '0;
    r.gen    = '0;
    r.status = gsa_pkg::STAT_DONE;
    case (rt)
      gsa_pkg::REQ_ALLOC: begin
        lim = (high_mark + 1 > SLOTS) ? SLOTS : high_mark + 1;
        i = low_free;
        while (i < lim && slot_busy[i]) i++;
        if (i < lim) begin
          // generation zero means no entity, so skip it on wrap
          slot_gen[i]  = (slot_gen[i] == '1) ? gsa_pkg::GenW'(1)
                                             : slot_gen[i] + gsa_pkg::GenW'(1);
          slot_busy[i] = 1'b1;
          if (high_mark < i + 1) high_mark = i + 1;
          low_free = i + 1;
          r.slot   = gsa_pkg::SlotIdW'(i);
          r.gen    = slot_gen[i];
        end else begin
          r.status = gsa_pkg::STAT_FULL;
        end
      end
      gsa_pkg::REQ_FREE: begin
        if (32'(sid) < SLOTS && slot_busy[sid]) begin
          slot_busy[sid] = 1'b0;
          if (32'(sid) < low_free) low_free = 32'(sid);
          r.slot = sid;
        end else begin
          r.status = gsa_pkg::STAT_IGNORED;
        end
      end
      gsa_pkg::REQ_CLEAR: begin
        // nothing at or above the mark was ever touched
        for (int unsigned k = 0; k < high_mark; k++) begin
          slot_busy[k] = 1'b0;
          slot_gen[k]  = '0;
        end
        high_mark = 0;
        low_free  = 0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      fail_count++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  // call at a falling edge; returns at the falling edge after the word is taken
  task automatic send_req(input logic [gsa_pkg::ReqTypeW-1:0] rt,
                          input logic [gsa_pkg::SlotIdW-1:0] sid,
                          input logic typed, input reply_t want);
    reply_t pred;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= rt;
    req_if.slot_id  <= sid;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    pred = apply_request(rt, sid);
    pending_replies.insert(pending_replies.size(), typed ? want : pred);
    @(negedge clk_i);
  endtask

  // result side: random stalls plus one long hold-off on request
  initial begin
    rsp_if.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left != 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HoldOffCycles - 1;
        rsp_if.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        stall_left   = $urandom_range(0, 14);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    reply_t want;
    if (rsp_if.valid && rsp_if.ready) begin
      if (pending_replies.size() == 0) begin
        fail_count++;
        $error("result word with no request outstanding: slot %0d gen %0d status %0d",
               rsp_if.slot_id_res, rsp_if.generation, rsp_if.status);
      end else begin
        want = pending_replies.pop_front();
        check_field("slot_id_res", 16'(want.slot), 16'(rsp_if.slot_id_res));
        check_field("generation", want.gen, rsp_if.generation);
        check_field("status", 16'(want.status), 16'(rsp_if.status));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    int unsigned                  pick;
    logic [gsa_pkg::ReqTypeW-1:0] rt;
    logic [gsa_pkg::SlotIdW-1:0]  sid;
    req_if.valid    = 1'b0;
    req_if.req_type = gsa_pkg::REQ_ALLOC;
    req_if.slot_id  = '0;
    rst_ni          = 1'b0;
    fail_count      = 0;
    quiet_cycles    = 0;
    gaps_on         = 1'b1;
    hold_off_req    = 1'b0;
    for (int unsigned k = 0; k < SLOTS; k++) begin
      slot_busy[k] = 1'b0;
      slot_gen[k]  = '0;
    end
    high_mark = 0;
    low_free  = 0;

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (steps[n]) send_req(steps[n].rt, steps[n].sid, steps[n].typed, steps[n].want);

    // mostly allocations and frees of ids up to the mark, some noise on top
    for (int n = 0; n < RandomCount; n++) begin
      gaps_on = (n < 900) && !(n >= 450 && n < 550);
      if (n == 300) hold_off_req = 1'b1;
      pick = $urandom_range(0, 99);
      sid  = gsa_pkg::SlotIdW'($urandom);
      if (pick < 50) begin
        rt = gsa_pkg::REQ_ALLOC;
      end else if (pick < 85) begin
        rt  = gsa_pkg::REQ_FREE;
        sid = gsa_pkg::SlotIdW'($urandom_range(0, high_mark));
      end else if (pick < 95) begin
        rt = gsa_pkg::REQ_FREE;
      end else if (pick < 99) begin
        rt = ReqUnused;
      end else begin
        rt = gsa_pkg::REQ_CLEAR;
      end
      send_req(rt, sid, 1'b0, '0);
    end
    req_if.valid <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/gsa_pkg.sv
rtl/gsa_req_if.sv
rtl/gsa_rsp_if.sv
rtl/gsa_top_map.sv
rtl/generational_slot_allocator.sv
rtl/gsa_checker.sv
sim/generational_slot_allocator_test.sv
